// ----- design/grc_pkg.sv -----
// Shared types, constants and the per-channel blend function of the color ramp.
// Used by grc_cell, grc_interp and gradient_color_ramp; depends on nothing.
`timescale 1ns / 1ps

package grc_pkg;

    localparam int K_MAX_STOPS = 16;
    localparam int K_IDX_W     = $clog2(K_MAX_STOPS);
    localparam int K_CNT_W     = $clog2(K_MAX_STOPS + 1);
    localparam int K_POS_W     = 16;
    localparam int K_CH_W      = 8;
    localparam int K_COL_W     = 4 * K_CH_W;

    localparam logic [K_POS_W-1:0] K_ONE  = 16'd32768;
    localparam logic [K_POS_W-1:0] K_HALF = 16'd16384;

    localparam logic [0:0] MODE_LOAD = 1'b0;
    localparam logic [0:0] MODE_EVAL = 1'b1;

    typedef logic [K_COL_W-1:0] t_color;

    typedef struct packed {
        logic [0:0]         mode;
        logic [K_IDX_W-1:0] stop_index;
        logic [K_POS_W-1:0] stop_position;
        logic [K_CH_W-1:0]  stop_red;
        logic [K_CH_W-1:0]  stop_green;
        logic [K_CH_W-1:0]  stop_blue;
        logic [K_CH_W-1:0]  stop_alpha;
        logic [K_POS_W-1:0] sample;
    } t_req;

    typedef struct packed {
        logic [K_CH_W-1:0] red;
        logic [K_CH_W-1:0] green;
        logic [K_CH_W-1:0] blue;
        logic [K_CH_W-1:0] alpha;
    } t_res;

    typedef struct packed {
        logic               en;
        logic [K_IDX_W-1:0] index;
        logic [K_POS_W-1:0] pos;
        t_color             col;
    } t_wr;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic               last;
        logic [K_POS_W-1:0] lo_pos;
        t_color             lo_col;
        logic [K_POS_W-1:0] hi_pos;
        t_color             hi_col;
    } t_token;

    function automatic logic [K_CH_W-1:0] blend_ch(input logic [K_CH_W-1:0] a,
                                                   input logic [K_CH_W-1:0] b,
                                                   input logic [K_POS_W-1:0] w);
        logic [K_CH_W+K_POS_W:0] acc;
        acc = (K_CH_W + K_POS_W + 1)'(a) * (K_CH_W + K_POS_W + 1)'(K_ONE - w)
            + (K_CH_W + K_POS_W + 1)'(b) * (K_CH_W + K_POS_W + 1)'(w)
            + (K_CH_W + K_POS_W + 1)'(K_HALF);
        return acc[K_CH_W+K_POS_W-2:K_POS_W-1];
    endfunction

endpackage

// ----- design/gradient_color_ramp.sv -----
// Top level of the gradient color ramp: stop register, row of stop cells, weight unit.
// Depends on grc_pkg, grc_cell and grc_interp.
//
//   channel   signals                    direction  handshake
//   request   start, busy, i_req         in         taken when start is high and busy is low
//   result    o_valid, o_res             out        one-cycle strobe, cannot be held off
//   config    i_cfg_we, i_cfg_data       in         written on any edge with i_cfg_we high, outside reset
//
// A load request leaves busy low. An evaluation walks a token down the 16-cell row, then,
// when it interpolates between two of three or more stops, runs the 16-step bit-serial divider
// for the weight, and then blends one channel per cycle. The strobe follows the blend of the
// last channel and busy drops in the cycle after the strobe, so a new evaluation is not taken
// before the last is through. Reset is synchronous and sets the stop count to one; the stop table is not cleared.
`timescale 1ns / 1ps

module gradient_color_ramp
    import grc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    output logic               o_valid,
    output t_res               o_res,
    input  logic               i_cfg_we,
    input  logic [K_CNT_W-1:0] i_cfg_data
);

    logic [K_CNT_W-1:0] r_count;
    logic               r_busy, n_busy;
    logic               r_inject;
    logic [K_POS_W-1:0] r_sample;
    logic [K_CNT_W-1:0] w_count;
    logic               w_take;
    t_wr                w_wr;
    t_token             w_inject;
    t_token             w_tok [0:K_MAX_STOPS];

    assign w_take = start && !busy;

    always_comb begin
        w_count = r_count;
        if (r_count == '0) begin
            w_count = K_CNT_W'(1);
        end else if (r_count > K_CNT_W'(K_MAX_STOPS)) begin
            w_count = K_CNT_W'(K_MAX_STOPS);
        end
    end

    assign w_wr.en    = w_take && (i_req.mode == MODE_LOAD);
    assign w_wr.index = i_req.stop_index;
    assign w_wr.pos   = i_req.stop_position;
    assign w_wr.col   = {i_req.stop_alpha, i_req.stop_blue, i_req.stop_green, i_req.stop_red};

    always_comb begin
        n_busy = r_busy;
        if (w_take && (i_req.mode == MODE_EVAL)) begin
            n_busy = 1'b1;
        end else if (o_valid) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= K_CNT_W'(1);
            r_busy   <= 1'b0;
            r_inject <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            r_busy   <= n_busy;
            r_inject <= w_take && (i_req.mode == MODE_EVAL);
        end
        if (w_take) begin
            r_sample <= i_req.sample;
        end
    end

    always_comb begin
        w_inject       = '0;
        w_inject.valid = r_inject;
    end

    assign w_tok[K_MAX_STOPS] = w_inject;

    for (genvar gi = 0; gi < K_MAX_STOPS; gi++) begin : g_cell
        grc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (K_IDX_W'(gi)),
            .i_wr     (w_wr),
            .i_sample (r_sample),
            .i_count  (w_count),
            .i_tok    (w_tok[gi+1]),
            .o_tok    (w_tok[gi])
        );
    end

    grc_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (w_tok[0]),
        .i_sample (r_sample),
        .i_count  (w_count),
        .o_valid  (o_valid),
        .o_res    (o_res)
    );

    assign busy = r_busy;

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe without a pending evaluation");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (i_req.mode == MODE_LOAD)) |=> !busy)
        else $error("load request made the block busy");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_valid))
        else $error("busy dropped without a result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_token_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[0].valid |-> busy)
        else $error("search token finished while idle");

endmodule

// ----- design/grc_cell.sv -----
// One stop cell of the ramp: holds a position and a color and passes the search token down.
// Depends on grc_pkg.
`timescale 1ns / 1ps

module grc_cell
    import grc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [K_IDX_W-1:0] i_index,
    input  t_wr                i_wr,
    input  logic [K_POS_W-1:0] i_sample,
    input  logic [K_CNT_W-1:0] i_count,
    input  t_token             i_tok,
    output t_token             o_tok
);

    logic [K_POS_W-1:0] r_pos;
    t_color             r_col;
    t_token             r_tok;
    t_token             n_tok;
    logic               w_active;
    logic               w_hit;
    logic               w_multi;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.index == i_index)) begin
            r_pos <= i_wr.pos;
            r_col <= i_wr.col;
        end
    end

    assign w_active = i_tok.valid && !i_tok.found && ({1'b0, i_index} < i_count);
    assign w_hit    = i_sample >= r_pos;
    assign w_multi  = i_count >= K_CNT_W'(3);

    always_comb begin
        n_tok = i_tok;
        if (w_active) begin
            if (i_index == '0) begin
                // The bottom cell always ends the walk.
                n_tok.found  = 1'b1;
                n_tok.last   = (i_count == K_CNT_W'(1)) || (w_multi && !w_hit);
                n_tok.lo_pos = r_pos;
                n_tok.lo_col = r_col;
            end else if (w_multi && w_hit) begin
                n_tok.found  = 1'b1;
                n_tok.last   = ({1'b0, i_index} == i_count - K_CNT_W'(1));
                n_tok.lo_pos = r_pos;
                n_tok.lo_col = r_col;
            end else begin
                n_tok.hi_pos = r_pos;
                n_tok.hi_col = r_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found  <= n_tok.found;
        r_tok.last   <= n_tok.last;
        r_tok.lo_pos <= n_tok.lo_pos;
        r_tok.lo_col <= n_tok.lo_col;
        r_tok.hi_pos <= n_tok.hi_pos;
        r_tok.hi_col <= n_tok.hi_col;
    end

    assign o_tok = r_tok;

endmodule

// ----- design/grc_interp.sv -----
// Weight unit of the ramp: bit-serial divider for the blend weight and a per-channel blender.
// Depends on grc_pkg.
`timescale 1ns / 1ps

module grc_interp
    import grc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_token             i_tok,
    input  logic [K_POS_W-1:0] i_sample,
    input  logic [K_CNT_W-1:0] i_count,
    output logic               o_valid,
    output t_res               o_res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_BLEND = 2'd2;
    localparam int         DIV_W    = 2 * K_POS_W;

    logic [1:0]         r_state, n_state;
    logic [4:0]         r_cnt, n_cnt;
    logic [K_POS_W-1:0] r_rem, n_rem;
    logic [K_POS_W-1:0] r_num, n_num;
    logic [K_POS_W-1:0] r_div, n_div;
    logic [K_POS_W-1:0] r_q, n_q;
    logic [K_POS_W-1:0] r_w, n_w;
    logic [1:0]         r_ch, n_ch;
    t_color             r_col_a, n_col_a;
    t_color             r_col_b, n_col_b;
    t_color             r_out, n_out;
    logic               r_valid, n_valid;

    logic [K_POS_W-1:0] w_range;
    logic [DIV_W-1:0]   w_num0;
    logic [K_POS_W:0]   w_rem_sh;
    logic [K_POS_W:0]   w_rem_sub;
    logic               w_ge;
    logic [K_CH_W-1:0]  w_ch;

    function automatic logic [K_POS_W-1:0] sat_w(input logic [K_POS_W-1:0] v);
        return (v > K_ONE) ? K_ONE : v;
    endfunction

    assign w_range   = i_tok.hi_pos - i_tok.lo_pos;
    assign w_num0    = {1'b0, i_sample - i_tok.lo_pos, 15'd0}
                     + {{(K_POS_W + 1){1'b0}}, w_range[K_POS_W-1:1]};
    assign w_rem_sh  = {r_rem, r_num[K_POS_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};
    assign w_ge      = w_rem_sh >= {1'b0, r_div};
    assign w_ch      = blend_ch(r_col_a[K_CH_W-1:0], r_col_b[K_CH_W-1:0], r_w);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_num   = r_num;
        n_div   = r_div;
        n_q     = r_q;
        n_w     = r_w;
        n_ch    = r_ch;
        n_col_a = r_col_a;
        n_col_b = r_col_b;
        n_out   = r_out;
        n_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_tok.valid) begin
                    n_col_a = i_tok.lo_col;
                    n_col_b = i_tok.hi_col;
                    n_ch    = 2'd0;
                    n_state = ST_BLEND;
                    if (i_tok.last) begin
                        n_w = '0;
                    end else if (i_count == K_CNT_W'(2)) begin
                        n_w = sat_w(i_sample);
                    end else if (i_tok.hi_pos > i_tok.lo_pos) begin
                        n_rem   = w_num0[DIV_W-1:K_POS_W];
                        n_num   = w_num0[K_POS_W-1:0];
                        n_div   = w_range;
                        n_q     = '0;
                        n_cnt   = 5'(K_POS_W);
                        n_state = ST_DIV;
                    end else begin
                        n_w = K_ONE;
                    end
                end
            end
            ST_DIV: begin
                n_rem = w_ge ? w_rem_sub[K_POS_W-1:0] : w_rem_sh[K_POS_W-1:0];
                n_num = {r_num[K_POS_W-2:0], 1'b0};
                n_q   = {r_q[K_POS_W-2:0], w_ge};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    n_w     = sat_w(n_q);
                    n_state = ST_BLEND;
                end
            end
            ST_BLEND: begin
                n_out   = {w_ch, r_out[K_COL_W-1:K_CH_W]};
                n_col_a = {{K_CH_W{1'b0}}, r_col_a[K_COL_W-1:K_CH_W]};
                n_col_b = {{K_CH_W{1'b0}}, r_col_b[K_COL_W-1:K_CH_W]};
                n_ch    = r_ch + 2'd1;
                if (r_ch == 2'd3) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_num   <= n_num;
        r_div   <= n_div;
        r_q     <= n_q;
        r_w     <= n_w;
        r_ch    <= n_ch;
        r_col_a <= n_col_a;
        r_col_b <= n_col_b;
        r_out   <= n_out;
    end

    assign o_valid     = r_valid;
    assign o_res.red   = r_out[K_CH_W-1:0];
    assign o_res.green = r_out[2*K_CH_W-1:K_CH_W];
    assign o_res.blue  = r_out[3*K_CH_W-1:2*K_CH_W];
    assign o_res.alpha = r_out[4*K_CH_W-1:3*K_CH_W];

endmodule
